// File: hw/rtl/cssim_pkg.sv
// shared types and constants for the cosine similarity stream block
`default_nettype none

package cssim_pkg;

	// fixed field widths of the streaming interface
	localparam int FIELD_BITS = 24;
	localparam int SIM_BITS   = 17;

	// accumulator and wide product widths
	localparam int ACC_BITS  = 60;
	localparam int HALF_BITS = ACC_BITS / 2;
	localparam int PROD_BITS = 2 * ACC_BITS;

	// defaults for the top level parameters
	localparam int ELEMENT_BITS_DEF = 24;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// similarity of exactly one in q1.16
	localparam logic [SIM_BITS-1:0] SIM_ONE = SIM_BITS'(65536);

	typedef struct packed {
		logic [FIELD_BITS-1:0] first_value;
		logic [FIELD_BITS-1:0] second_value;
		logic                  last_pair;
	} cssim_in_t;

	typedef struct packed {
		logic [SIM_BITS-1:0] similarity;
		logic                zero_magnitude;
	} cssim_out_t;

	// finished sums of one vector pair
	typedef struct packed {
		logic [ACC_BITS-1:0] dot_sum;
		logic [ACC_BITS-1:0] first_energy;
		logic [ACC_BITS-1:0] second_energy;
	} cssim_sums_t;

endpackage

`default_nettype wire

// File: hw/rtl/cssim_front.sv
// front end: element products and running sums, one pair per cycle while full is low
`default_nettype none

module cssim_front #(
	parameter int ELEMENT_BITS = cssim_pkg::ELEMENT_BITS_DEF,
	parameter int QUEUE_DEPTH  = cssim_pkg::QUEUE_DEPTH_DEF,
	parameter int CNT_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cssim_pkg::cssim_in_t  item,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [CNT_BITS-1:0]   q_count,
	output logic                       q_push,
	output cssim_pkg::cssim_sums_t     q_data
);
	import cssim_pkg::*;

	localparam int PBITS = 2 * ELEMENT_BITS;

	logic                    accept;
	logic                    vld_s1;
	logic                    last_s1;
	logic [ELEMENT_BITS-1:0] a_s1;
	logic [ELEMENT_BITS-1:0] b_s1;
	logic                    vld_s2;
	logic                    last_s2;
	logic [PBITS-1:0]        pab_s2;
	logic [PBITS-1:0]        paa_s2;
	logic [PBITS-1:0]        pbb_s2;
	logic [ACC_BITS-1:0]     dot_q;
	logic [ACC_BITS-1:0]     e1_q;
	logic [ACC_BITS-1:0]     e2_q;
	cssim_sums_t             sum;

	// up to two vector ends may still be in flight, keep room for them
	assign full   = q_count >= CNT_BITS'(QUEUE_DEPTH - 2);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= item.first_value[ELEMENT_BITS-1:0];
		b_s1    <= item.second_value[ELEMENT_BITS-1:0];
		last_s1 <= item.last_pair;
		pab_s2  <= a_s1 * b_s1;
		paa_s2  <= a_s1 * a_s1;
		pbb_s2  <= b_s1 * b_s1;
		last_s2 <= last_s1;
	end

	always_comb begin
		sum.dot_sum       = dot_q + ACC_BITS'(pab_s2);
		sum.first_energy  = e1_q + ACC_BITS'(paa_s2);
		sum.second_energy = e2_q + ACC_BITS'(pbb_s2);
	end

	assign q_push = vld_s2 && last_s2;
	assign q_data = sum;

	// sums restart after the last pair of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			e1_q  <= '0;
			e2_q  <= '0;
		end else if (vld_s2) begin
			if (last_s2) begin
				dot_q <= '0;
				e1_q  <= '0;
				e2_q  <= '0;
			end else begin
				dot_q <= sum.dot_sum;
				e1_q  <= sum.first_energy;
				e2_q  <= sum.second_energy;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/cssim_queue.sv
// short queue of finished sums between front and back end
`default_nettype none

module cssim_queue #(
	parameter int QUEUE_DEPTH = cssim_pkg::QUEUE_DEPTH_DEF,
	parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire cssim_pkg::cssim_sums_t wr_data,
	input  wire logic                   rd_en,
	output cssim_pkg::cssim_sums_t      rd_data,
	output logic                        q_empty,
	output logic [CNT_BITS-1:0]         count
);
	import cssim_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	cssim_sums_t         mem [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
		if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_BITS'(1);
	endfunction

	assign rd_data = mem[rd_ptr_q];
	assign q_empty = count_q == '0;
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/cssim_back.sv
// back end: wide products, long division and square root of the ratio
`default_nettype none

module cssim_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cssim_pkg::cssim_sums_t q_data,
	input  wire logic                   q_empty,
	output logic                        q_pop,
	output cssim_pkg::cssim_out_t       result,
	output logic                        empty,
	input  wire logic                   pop
);
	import cssim_pkg::*;

	localparam int ST_BITS    = 3;
	localparam int CNT_BITS   = 6;
	localparam int MUL_STEPS  = 8;
	localparam int DIV_STEPS  = 32;
	localparam int SQRT_STEPS = 16;
	localparam int ROOT_BITS  = 16;
	localparam int REM_BITS   = ROOT_BITS + 2;

	localparam logic [ST_BITS-1:0] S_IDLE = 3'd0;
	localparam logic [ST_BITS-1:0] S_MUL  = 3'd1;
	localparam logic [ST_BITS-1:0] S_CHK  = 3'd2;
	localparam logic [ST_BITS-1:0] S_DIV  = 3'd3;
	localparam logic [ST_BITS-1:0] S_SQRT = 3'd4;
	localparam logic [ST_BITS-1:0] S_DONE = 3'd5;

	logic [ST_BITS-1:0]   state_q;
	logic [CNT_BITS-1:0]  cnt_q;
	cssim_sums_t          sums_q;
	logic [PROD_BITS-1:0] dd_q;
	logic [PROD_BITS-1:0] pp_q;
	logic [ACC_BITS-1:0]  mp_q;
	logic [1:0]           mp_sh_q;
	logic                 mp_tgt_q;
	logic                 mp_vld_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	cssim_out_t           res_q;
	cssim_out_t           out_q;
	logic                 out_vld_q;

	logic                 mul_issue;
	logic [ACC_BITS-1:0]  mul_x;
	logic [ACC_BITS-1:0]  mul_y;
	logic [HALF_BITS-1:0] x_part;
	logic [HALF_BITS-1:0] y_part;
	logic [ACC_BITS-1:0]  mul_full;
	logic [PROD_BITS-1:0] addend;
	logic [PROD_BITS:0]   div_sh;
	logic [PROD_BITS:0]   div_diff;
	logic                 div_ge;
	logic [REM_BITS+1:0]  sq_sh;
	logic [REM_BITS+1:0]  sq_trial;
	logic [REM_BITS+1:0]  sq_diff;
	logic                 sq_ge;
	logic                 zero_in;
	logic                 out_free;

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign zero_in  = (q_data.first_energy == '0) || (q_data.second_energy == '0);
	assign out_free = !out_vld_q || pop;

	// partial products: first four steps square the dot sum, last four multiply energies
	assign mul_issue = (state_q == S_MUL) && (cnt_q < CNT_BITS'(MUL_STEPS));
	assign mul_x     = cnt_q[2] ? sums_q.first_energy : sums_q.dot_sum;
	assign mul_y     = cnt_q[2] ? sums_q.second_energy : sums_q.dot_sum;
	assign x_part    = cnt_q[1] ? mul_x[ACC_BITS-1:HALF_BITS] : mul_x[HALF_BITS-1:0];
	assign y_part    = cnt_q[0] ? mul_y[ACC_BITS-1:HALF_BITS] : mul_y[HALF_BITS-1:0];
	assign mul_full  = x_part * y_part;

	always_comb begin
		case (mp_sh_q)
			2'd0:    addend = {{ACC_BITS{1'b0}}, mp_q};
			2'd1:    addend = {{HALF_BITS{1'b0}}, mp_q, {HALF_BITS{1'b0}}};
			2'd2:    addend = {mp_q, {ACC_BITS{1'b0}}};
			default: addend = '0;
		endcase
	end

	// restoring division step, remainder always below the divisor
	assign div_sh   = {dd_q, 1'b0};
	assign div_diff = div_sh - {1'b0, pp_q};
	assign div_ge   = div_sh >= {1'b0, pp_q};

	// square root digit step, two quotient bits per step
	assign sq_sh    = {rem_q, quo_q[DIV_STEPS-1:DIV_STEPS-2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_diff  = sq_sh - sq_trial;
	assign sq_ge    = sq_sh >= sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			mp_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			mp_vld_q <= mul_issue;
			if ((state_q == S_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (!q_empty) begin
						state_q <= zero_in ? S_DONE : S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(MUL_STEPS)) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					cnt_q   <= '0;
					state_q <= (dd_q >= pp_q) ? S_DONE : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(SQRT_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_issue) begin
			mp_q     <= mul_full;
			mp_sh_q  <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			mp_tgt_q <= cnt_q[2];
		end
		if (mp_vld_q) begin
			if (mp_tgt_q) begin
				pp_q <= pp_q + addend;
			end else begin
				dd_q <= dd_q + addend;
			end
		end
		case (state_q)
			S_IDLE: begin
				sums_q <= q_data;
				dd_q   <= '0;
				pp_q   <= '0;
				res_q  <= '{similarity: '0, zero_magnitude: 1'b1};
			end
			S_CHK: begin
				// ratio at or above one saturates
				res_q  <= '{similarity: SIM_ONE, zero_magnitude: 1'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			S_DIV: begin
				dd_q  <= div_ge ? div_diff[PROD_BITS-1:0] : div_sh[PROD_BITS-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], div_ge};
			end
			S_SQRT: begin
				rem_q  <= sq_ge ? sq_diff[REM_BITS-1:0] : sq_sh[REM_BITS-1:0];
				root_q <= {root_q[ROOT_BITS-2:0], sq_ge};
				quo_q  <= {quo_q[DIV_STEPS-3:0], 2'b00};
				if (cnt_q == CNT_BITS'(SQRT_STEPS - 1)) begin
					res_q <= '{similarity: SIM_BITS'({root_q[ROOT_BITS-2:0], sq_ge}),
						zero_magnitude: 1'b0};
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result = out_q;
	assign empty  = !out_vld_q;

endmodule

`default_nettype wire

// File: hw/rtl/cosine_similarity_stream_top.sv
// top level of the streaming cosine similarity block
// usage:
//   input side is a queue write port: a transaction moves one element pair
//   (first_value, second_value, last_pair) when push is high and full is low.
//   send exactly as many pairs as the shorter vector holds, marking the final
//   one with last_pair.
//   result side is a queue read port: while empty is low, result carries the
//   similarity of the oldest finished vector pair in q1.16 (65536 means 1.0,
//   rounded down) and zero_magnitude; pop with empty low takes it.
// throughput: one pair per cycle on the input while full is low, set by the
//   front end products and adders. the back end takes one vector pair at a
//   time and ends it before the next: load, product steps, 1 range check, 32
//   division steps, 16 root steps, hand-off, with the shared 30x30 multiplier
//   and the one-bit division and two-bit root loops. the sum queue lets several
//   vector ends wait, so vectors longer than that back end work do not stall.
// short paths: a zero magnitude vector goes from load straight to hand-off,
//   and a saturated ratio skips division and root.
// reset clears the running sums, the sum queue and the result valid flag;
//   full and empty go to zero and one at once.
// a stalled receiver holds the result; the back end finishes the next vector
//   and waits, then the sum queue fills and full rises.
`default_nettype none

module cosine_similarity_stream_top #(
	parameter int ELEMENT_BITS = cssim_pkg::ELEMENT_BITS_DEF,
	parameter int QUEUE_DEPTH  = cssim_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cssim_pkg::cssim_in_t  item,
	input  wire logic                  push,
	output logic                       full,
	output cssim_pkg::cssim_out_t      result,
	output logic                       empty,
	input  wire logic                  pop
);
	import cssim_pkg::*;

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// front to queue
	logic                q_push;
	cssim_sums_t         q_wdata;
	logic [CNT_BITS-1:0] q_count;
	// queue to back
	logic                q_pop;
	cssim_sums_t         q_rdata;
	logic                q_empty;

	// products and running sums, one pair per cycle while full is low
	cssim_front #(
		.ELEMENT_BITS(ELEMENT_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_BITS    (CNT_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.q_count(q_count),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// finished sums wait here for the back end
	cssim_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.CNT_BITS   (CNT_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.rd_en  (q_pop),
		.rd_data(q_rdata),
		.q_empty(q_empty),
		.count  (q_count)
	);

	// ratio and root, one vector pair at a time
	cssim_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (q_rdata),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule

`default_nettype wire

// File: sim/cosine_similarity_stream_top_test.sv
// self-checking testbench for the streaming cosine similarity block
`default_nettype none

module cosine_similarity_stream_top_test;
	import cssim_pkg::*;

	// cycles with no accepted transaction on either side before the run is abandoned
	localparam int QUIET_LIMIT = 2000;
	// cycles to keep watching for stray results once nothing is expected
	localparam int TAIL_CYCLES = 150;
	localparam int RANDOM_PAIRS = 1000;
	localparam logic [FIELD_BITS-1:0] ELEM_MAX = '1;
	localparam logic [ACC_BITS-1:0] ELEM_MASK = ACC_BITS'((64'd1 << ELEMENT_BITS_DEF) - 1);

	// how the second element of each pair relates to the first within one vector
	typedef enum int {
		PAIR_FREE,
		PAIR_EQUAL,
		PAIR_SCALED,
		PAIR_NEAR,
		PAIR_ONE_ZERO
	} pair_mode_e;

	// one queued element pair; settle means wait for all results before sending it
	typedef struct {
		cssim_in_t pair;
		bit        settle;
	} queued_pair_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	cssim_in_t  item = '0;
	logic       push = 1'b0;
	logic       full;
	cssim_out_t result;
	logic       empty;
	logic       pop = 1'b0;

	cosine_similarity_stream_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

	always #2 clk = ~clk;

	queued_pair_t pair_queue[$];
	cssim_out_t   sims_expected[$];

	// running sums of the vector pair now streaming in, wrapped like the hardware
	logic [ACC_BITS-1:0] dot_acc = '0;
	logic [ACC_BITS-1:0] first_acc = '0;
	logic [ACC_BITS-1:0] second_acc = '0;

	int  failures = 0;
	int  quiet_cycles = 0;
	// transaction flags from the last rising edge, read by the drivers at the falling edge
	logic in_took = 1'b0;
	logic out_took = 1'b0;
	int  send_gap = 0;
	int  take_gap = 0;
	bit  send_burst = 1'b0;
	bit  take_burst = 1'b0;

	// largest r in 0..65536 with r*r*m1*m2 <= (65536*dot)^2, by bisection
	function automatic logic [SIM_BITS-1:0] cosine_floor(input logic [ACC_BITS-1:0] dot,
			input logic [ACC_BITS-1:0] m1, input logic [ACC_BITS-1:0] m2);
		logic [255:0] energy_prod;
		logic [255:0] dot_scaled;
		logic [255:0] trial;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		energy_prod = 256'(m1) * 256'(m2);
		dot_scaled = (256'(dot) * 256'(dot)) << 32;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			trial = 256'(mid) * 256'(mid) * energy_prod;
			if (trial <= dot_scaled)
				lo = mid;
			else
				hi = mid - 1;
		end
		return SIM_BITS'(lo);
	endfunction

	// fold one accepted pair into the sums; on the last pair queue the expected result
	task automatic take_pair(input cssim_in_t p);
		logic [ACC_BITS-1:0] a;
		logic [ACC_BITS-1:0] b;
		cssim_out_t sim;
		a = ACC_BITS'(p.first_value) & ELEM_MASK;
		b = ACC_BITS'(p.second_value) & ELEM_MASK;
		dot_acc = dot_acc + a * b;
		first_acc = first_acc + a * a;
		second_acc = second_acc + b * b;
		if (p.last_pair) begin
			// a vector with no energy gives zero and raises the flag
			if (first_acc == '0 || second_acc == '0) begin
				sim.similarity = '0;
				sim.zero_magnitude = 1'b1;
			end else begin
				sim.similarity = cosine_floor(dot_acc, first_acc, second_acc);
				sim.zero_magnitude = 1'b0;
			end
			sims_expected = {sims_expected, sim};
			dot_acc = '0;
			first_acc = '0;
			second_acc = '0;
		end
	endtask

	task automatic add_pair(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b,
			input bit last, input bit settle);
		queued_pair_t q;
		q.pair.first_value = a;
		q.pair.second_value = b;
		q.pair.last_pair = last;
		q.settle = settle;
		pair_queue = {pair_queue, q};
	endtask

	function automatic logic [FIELD_BITS-1:0] draw_elem();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ELEM_MAX;
			2: return FIELD_BITS'($urandom_range(0, 15));
			3: return ~FIELD_BITS'($urandom_range(0, 255));
			default: return FIELD_BITS'($urandom);
		endcase
	endfunction

	task automatic add_vector(input int len, input pair_mode_e mode, input bit settle);
		logic [FIELD_BITS-1:0] a;
		logic [FIELD_BITS-1:0] b;
		bit zero_first;
		zero_first = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			a = draw_elem();
			case (mode)
				PAIR_EQUAL: b = a;
				PAIR_SCALED: b = a >> 1;
				PAIR_NEAR: b = a ^ FIELD_BITS'($urandom_range(0, 3));
				PAIR_ONE_ZERO: begin
					b = draw_elem();
					if (zero_first)
						a = '0;
					else
						b = '0;
				end
				default: b = draw_elem();
			endcase
			add_pair(a, b, i == len - 1, settle && i == 0);
		end
	endtask

	// sender: holds each pair until taken, then idles for a drawn number of cycles
	always @(negedge clk) begin
		logic push_next;
		push_next = 1'b0;
		if (arst_n) begin
			if (push && !in_took) begin
				push_next = 1'b1;
			end else begin
				if (push) begin
					// occasionally flip into or out of a stretch with no idling
					if ($urandom_range(0, 31) == 0)
						send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 9);
				end
				if (send_gap > 0) begin
					send_gap--;
				end else if (pair_queue.size() != 0 &&
						!(pair_queue[0].settle && sims_expected.size() != 0)) begin
					item <= pair_queue[0].pair;
					pair_queue.pop_front();
					push_next = 1'b1;
				end
			end
		end
		push <= push_next;
	end

	// receiver: after each taken result it stalls for a drawn number of cycles
	always @(negedge clk) begin
		logic pop_next;
		pop_next = 1'b0;
		if (arst_n) begin
			if (pop && out_took) begin
				if ($urandom_range(0, 31) == 0)
					take_burst = !take_burst;
				take_gap = take_burst ? 0 : $urandom_range(0, 9);
			end
			if (take_gap > 0)
				take_gap--;
			else
				pop_next = 1'b1;
		end
		pop <= pop_next;
	end

	// monitor: predicts on input transactions, checks output transactions, runs the watchdog
	always @(posedge clk) begin
		cssim_out_t want;
		in_took <= push && !full;
		out_took <= pop && !empty;
		if (arst_n) begin
			if (push && !full)
				take_pair(item);
			if (pop && !empty) begin
				if (sims_expected.size() == 0) begin
					$error("result with nothing expected: similarity %0d zero_magnitude %0d",
						result.similarity, result.zero_magnitude);
					failures++;
				end else begin
					want = sims_expected.pop_front();
					if (result.similarity !== want.similarity) begin
						$error("similarity: expected %0d actual %0d",
							want.similarity, result.similarity);
						failures++;
					end
					if (result.zero_magnitude !== want.zero_magnitude) begin
						$error("zero_magnitude: expected %0d actual %0d",
							want.zero_magnitude, result.zero_magnitude);
						failures++;
					end
				end
			end
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int len;
		int pick;
		// directed: identical maximal vectors give exactly one
		add_pair(ELEM_MAX, ELEM_MAX, 1'b1, 1'b0);
		// zero magnitude on both, first only, second only
		add_pair('0, '0, 1'b1, 1'b0);
		add_pair('0, ELEM_MAX, 1'b1, 1'b0);
		add_pair(ELEM_MAX, '0, 1'b1, 1'b0);
		// orthogonal vectors give zero without the flag
		add_pair(24'd1, '0, 1'b0, 1'b0);
		add_pair('0, 24'd1, 1'b1, 1'b0);
		// extremes crossed
		add_pair(ELEM_MAX, 24'd1, 1'b0, 1'b0);
		add_pair(24'd1, ELEM_MAX, 1'b1, 1'b0);
		add_pair(24'd1, 24'd1, 1'b1, 1'b0);
		// alternating bit patterns
		add_pair(24'hAAAAAA, 24'h555555, 1'b0, 1'b0);
		add_pair(24'h555555, 24'hAAAAAA, 1'b1, 1'b0);
		add_pair(24'hAAAAAA, 24'hAAAAAA, 1'b0, 1'b0);
		add_pair(24'h555555, 24'h555555, 1'b1, 1'b0);
		// zero pair in the middle of a vector; the sender waits for the backlog to drain first
		add_pair(24'd3, 24'd4, 1'b0, 1'b1);
		add_pair('0, '0, 1'b0, 1'b0);
		add_pair(24'd4, 24'd3, 1'b1, 1'b0);

		// random vectors, mostly short, now and then long
		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				len = $urandom_range(1, 8);
			else if (pick < 19)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(100, 300);
			add_vector(len, pair_mode_e'($urandom_range(PAIR_FREE, PAIR_ONE_ZERO)),
				$urandom_range(0, 24) == 0);
			sent += len;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pair_queue.size() != 0 || push || sims_expected.size() != 0)
			@(posedge clk);
		// keep watching for results that should not come
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && sims_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/cssim_pkg.sv
hw/rtl/cssim_front.sv
hw/rtl/cssim_queue.sv
hw/rtl/cssim_back.sv
hw/rtl/cosine_similarity_stream_top.sv
sim/cosine_similarity_stream_top_test.sv
